// ===== hdl/sbce_pkg.sv =====
// Package for the 16-bit CPU execute block: item and result types, register indices, reset values, codes.
// No dependencies.
`timescale 1ns / 1ps
package sbce_pkg;
    localparam int PC_IDX = 15;
    localparam int SP_IDX = 14;
    localparam logic [15:0] SP_RESET = 16'hFFFC;
    localparam logic [31:0] LIMIT_RESET = 32'd65535;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [2:0] EXC_NONE  = 3'd0;
    localparam logic [2:0] EXC_FETCH = 3'd1;
    localparam logic [2:0] EXC_LIMIT = 3'd2;
    localparam logic [2:0] EXC_OPC   = 3'd3;
    localparam logic [2:0] EXC_DIV0  = 3'd4;
    localparam logic [2:0] EXC_RD    = 3'd5;
    localparam logic [2:0] EXC_WR    = 3'd6;

    localparam logic [0:0] CFG_ENTRY = 1'd0;
    localparam logic [0:0] CFG_LIMIT = 1'd1;

    // item as queued between front and back
    typedef struct packed {
        logic        op;
        logic [15:0] instr;
        logic        fetch_fault;
        logic [15:0] rand_value;
        logic [15:0] seed_word;
        logic [15:0] mem_data;
        logic        mem_fault;
    } t_item;

    typedef struct packed {
        logic [15:0] pc;
        logic [1:0]  mem_req;
        logic [15:0] mem_addr;
        logic [15:0] mem_wdata;
        logic [1:0]  dma_req;
        logic [7:0]  dma_device;
        logic [15:0] dma_addr;
        logic [15:0] dma_len;
        logic [2:0]  exception;
        logic [31:0] instr_count;
    } t_result;
endpackage

// ===== hdl/sbce_front.sv =====
// Front: accepts items into a two-entry queue toward the back.
// Depends on sbce_pkg.
`timescale 1ns / 1ps
module sbce_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  sbce_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output sbce_pkg::t_item o_item
);
    sbce_pkg::t_item r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    // store payload
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_item;
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_valid) else $error("valid with empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !w_pop) |=> o_full) else $error("full dropped without pop");
endmodule

// ===== hdl/sbce_div.sv =====
// Iterative 16-bit unsigned divider, one quotient bit per cycle.
// No package dependencies.
`timescale 1ns / 1ps
module sbce_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    logic [15:0] r_q, r_den;
    logic [16:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_sh;

    assign w_sh   = {r_rem[15:0], r_q[15]};
    assign o_quo  = r_q;
    assign o_done = r_busy && r_cnt == 5'd0;

    // shift-subtract step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1; r_cnt <= 5'd16;
            r_q <= i_num; r_den <= i_den; r_rem <= 17'd0;
        end else if (r_busy && r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q <= {r_q[14:0], 1'b0};
            end
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
endmodule

// ===== hdl/sbce_back.sv =====
// Back: executes one queued item against the register file, emits one result.
// Depends on sbce_pkg and sbce_div.
`timescale 1ns / 1ps
module sbce_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_take,
    input  sbce_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output logic              o_res_valid,
    input  logic              i_res_pop,
    output sbce_pkg::t_result o_res
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [15:0] r_rf [16];
    logic [31:0] r_cnt, r_lim;
    logic [7:0]  r_dev;
    logic        r_halt;
    logic [1:0]  r_pend;
    logic [3:0]  r_pdst;
    logic [1:0]  r_st;
    logic [3:0]  r_ddst;
    sbce_pkg::t_result r_res, n_res;

    // decode fields
    logic [15:0] w_ins, w_pc2;
    logic [2:0]  w_grp;
    logic [3:0]  w_d, w_l, w_r, w_sub, w_idst, w_creg;
    logic [6:0]  w_imm7;
    logic [7:0]  w_imm8;
    logic        w_b12, w_go;
    logic [15:0] w_rd, w_rl, w_rr, w_ri, w_rc;

    logic        we_a, we_b, we_pc, w_div, n_halt;
    logic [3:0]  wa_a, wa_b;
    logic [15:0] wd_a, wd_b, wd_pc, w_dn, w_dd;
    logic [31:0] n_cnt, w_prod;
    logic [7:0]  n_dev;
    logic [1:0]  n_pend;
    logic [3:0]  n_pdst;
    logic        w_dstart, w_ddone;
    logic [15:0] w_quo;
    logic [15:0] n_rf [16];
    logic [15:0] w_rf_we;

    assign w_ins  = i_item.instr;
    assign w_grp  = w_ins[15:13];
    assign w_b12  = w_ins[12];
    assign w_d    = w_ins[11:8];
    assign w_l    = w_ins[7:4];
    assign w_r    = w_ins[3:0];
    assign w_sub  = w_ins[11:8];
    assign w_idst = w_ins[10:7];
    assign w_creg = w_ins[12:9];
    assign w_imm7 = w_ins[6:0];
    assign w_imm8 = w_ins[7:0];
    assign w_pc2  = r_rf[sbce_pkg::PC_IDX] + 16'd2;
    // operand reads see the PC already advanced
    assign w_rd   = (w_d == 4'(sbce_pkg::PC_IDX)) ? w_pc2 : r_rf[w_d];
    assign w_rl   = (w_l == 4'(sbce_pkg::PC_IDX)) ? w_pc2 : r_rf[w_l];
    assign w_rr   = (w_r == 4'(sbce_pkg::PC_IDX)) ? w_pc2 : r_rf[w_r];
    assign w_ri   = (w_idst == 4'(sbce_pkg::PC_IDX)) ? w_pc2 : r_rf[w_idst];
    assign w_rc   = (w_creg == 4'(sbce_pkg::PC_IDX)) ? w_pc2 : r_rf[w_creg];
    assign w_go   = i_valid && r_st == ST_IDLE;
    assign o_take = w_go;
    assign o_res_valid = r_st == ST_OUT;
    assign o_res  = r_res;
    assign w_prod = (w_grp == 3'd4) ? {16'd0, w_ri} * {25'd0, w_imm7}
                                    : {16'd0, w_rl} * {16'd0, w_rr};
    assign w_dstart = w_go && w_div;

    sbce_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dn), .i_den(w_dd), .o_done(w_ddone), .o_quo(w_quo)
    );

    // execute one item
    always_comb begin
        we_a = 1'b0; we_b = 1'b0; we_pc = 1'b0; w_div = 1'b0;
        wa_a = w_d; wa_b = w_r; wd_a = 16'd0; wd_b = 16'd0; wd_pc = w_pc2;
        w_dn = w_rl; w_dd = w_rr;
        n_cnt = r_cnt; n_dev = r_dev; n_pend = r_pend; n_pdst = r_pdst;
        n_halt = r_halt;
        n_res = '0;
        if (!r_halt) begin
            if (i_item.op) begin
                if (r_pend != sbce_pkg::REQ_NONE) begin
                    if (i_item.mem_fault)
                        n_res.exception = (r_pend == sbce_pkg::REQ_READ) ?
                            sbce_pkg::EXC_RD : sbce_pkg::EXC_WR;
                    else if (r_pend == sbce_pkg::REQ_READ) begin
                        we_a = 1'b1; wa_a = r_pdst; wd_a = i_item.mem_data;
                    end
                    n_pend = sbce_pkg::REQ_NONE;
                end
            end else if (r_pend == sbce_pkg::REQ_NONE) begin
                we_pc = 1'b1;
                if (i_item.fetch_fault) begin
                    n_res.exception = sbce_pkg::EXC_FETCH;
                end else begin
                    n_cnt = r_cnt + 32'd1;
                    if (r_cnt > r_lim) begin
                        n_res.exception = sbce_pkg::EXC_LIMIT;
                    end else begin
                        unique case (w_grp)
                            3'd0: begin
                                we_a = 1'b1;
                                wd_a = w_b12 ? {w_rd[15:8], w_imm8} : {w_imm8, w_rd[7:0]};
                            end
                            3'd1: begin
                                we_a = 1'b1;
                                wd_a = w_b12 ? w_rl - w_rr : w_rl + w_rr;
                            end
                            3'd2: begin
                                if (!w_b12) begin
                                    we_a = 1'b1; wd_a = w_prod[15:0];
                                end else if (w_rr == 16'd0)
                                    n_res.exception = sbce_pkg::EXC_DIV0;
                                else
                                    w_div = 1'b1;
                            end
                            3'd3: begin
                                wa_a = w_l;
                                unique case (w_sub)
                                    4'd0: begin we_a = 1'b1; wd_a = w_rr; end
                                    4'd1: begin
                                        we_a = 1'b1; wd_a = w_rr;
                                        we_b = 1'b1; wd_b = w_rl;
                                    end
                                    4'd2: if (w_rl == 16'd0) wd_pc = w_pc2 + w_rr;
                                    4'd3: if (w_rl != 16'd0) wd_pc = w_pc2 + w_rr;
                                    4'd4: n_dev = w_imm8;
                                    4'd5, 4'd6: begin
                                        n_res.dma_req = (w_sub == 4'd5) ?
                                            sbce_pkg::REQ_READ : sbce_pkg::REQ_WRITE;
                                        n_res.dma_device = r_dev;
                                        n_res.dma_addr = w_rl;
                                        n_res.dma_len = w_rr;
                                    end
                                    4'd7: wd_pc = w_pc2 + {8'd0, w_imm8};
                                    4'd8: wd_pc = w_pc2 - {8'd0, w_imm8};
                                    4'd9: wd_pc = w_rr;
                                    4'd10: begin
                                        we_b = 1'b1; wd_b = n_cnt[31:16];
                                        we_a = 1'b1; wd_a = n_cnt[15:0];
                                    end
                                    4'd11: begin we_b = 1'b1; wd_b = i_item.rand_value; end
                                    4'd12: begin
                                        we_b = 1'b1;
                                        wd_b = i_item.rand_value ^ i_item.seed_word;
                                    end
                                    4'd13: begin
                                        n_res.mem_req = sbce_pkg::REQ_READ;
                                        n_res.mem_addr = w_rr;
                                        n_pend = sbce_pkg::REQ_READ; n_pdst = w_l;
                                    end
                                    4'd14: begin
                                        n_res.mem_req = sbce_pkg::REQ_WRITE;
                                        n_res.mem_addr = w_rr; n_res.mem_wdata = w_rl;
                                        n_pend = sbce_pkg::REQ_WRITE; n_pdst = w_l;
                                    end
                                    default: n_res.exception = sbce_pkg::EXC_OPC;
                                endcase
                            end
                            3'd4: begin
                                wa_a = w_idst;
                                w_dn = w_ri; w_dd = {9'd0, w_imm7};
                                unique case (w_ins[12:11])
                                    2'd0: begin we_a = 1'b1; wd_a = w_ri + {9'd0, w_imm7}; end
                                    2'd1: begin we_a = 1'b1; wd_a = w_ri - {9'd0, w_imm7}; end
                                    2'd2: begin we_a = 1'b1; wd_a = w_prod[15:0]; end
                                    default: begin
                                        if (w_imm7 == 7'd0) n_res.exception = sbce_pkg::EXC_DIV0;
                                        else w_div = 1'b1;
                                    end
                                endcase
                            end
                            3'd5: begin
                                if (w_b12 ? (w_rd > w_rl) : (w_rd < w_rl))
                                    wd_pc = w_pc2 + w_rr;
                            end
                            default: begin
                                if ((w_rc == 16'd0) ^ (w_grp == 3'd7))
                                    wd_pc = w_ins[8] ? w_pc2 - {7'd0, w_imm8, 1'b0}
                                                     : w_pc2 + {7'd0, w_imm8, 1'b0};
                            end
                        endcase
                    end
                end
            end
            if (n_res.exception != sbce_pkg::EXC_NONE) n_halt = 1'b1;
        end
        n_res.instr_count = n_cnt;
        // report the PC as it stands after every write of this item
        n_res.pc = r_rf[sbce_pkg::PC_IDX];
        if (we_pc) n_res.pc = wd_pc;
        if (we_b && wa_b == 4'(sbce_pkg::PC_IDX)) n_res.pc = wd_b;
        if (we_a && wa_a == 4'(sbce_pkg::PC_IDX)) n_res.pc = wd_a;
    end

    // merge register writes, later writers of this item take priority
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            w_rf_we[k] = 1'b0;
            n_rf[k] = 16'd0;
            if (i_cfg_we && i_cfg_idx == sbce_pkg::CFG_ENTRY && k == sbce_pkg::PC_IDX) begin
                w_rf_we[k] = 1'b1; n_rf[k] = i_cfg_data[15:0];
            end
            if (w_go) begin
                if (we_pc && k == sbce_pkg::PC_IDX) begin
                    w_rf_we[k] = 1'b1; n_rf[k] = wd_pc;
                end
                if (we_b && wa_b == 4'(k)) begin
                    w_rf_we[k] = 1'b1; n_rf[k] = wd_b;
                end
                if (we_a && wa_a == 4'(k)) begin
                    w_rf_we[k] = 1'b1; n_rf[k] = wd_a;
                end
            end
            if (r_st == ST_DIV && w_ddone && r_ddst == 4'(k)) begin
                w_rf_we[k] = 1'b1; n_rf[k] = w_quo;
            end
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 16; k++) begin
            if (!i_rst_n)
                r_rf[k] <= (k == sbce_pkg::SP_IDX) ? sbce_pkg::SP_RESET : 16'd0;
            else if (w_rf_we[k])
                r_rf[k] <= n_rf[k];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 32'd0; r_lim <= sbce_pkg::LIMIT_RESET; r_dev <= 8'd0;
            r_halt <= 1'b0; r_pend <= sbce_pkg::REQ_NONE; r_pdst <= 4'd0;
            r_st <= ST_IDLE;
        end else begin
            if (i_cfg_we && i_cfg_idx == sbce_pkg::CFG_LIMIT) r_lim <= i_cfg_data;
            unique case (r_st)
                ST_IDLE: if (w_go) begin
                    r_cnt <= n_cnt; r_dev <= n_dev; r_pend <= n_pend;
                    r_pdst <= n_pdst; r_halt <= n_halt;
                    r_res <= n_res;
                    r_ddst <= wa_a;
                    r_st <= w_div ? ST_DIV : ST_OUT;
                end
                ST_DIV: if (w_ddone) begin
                    if (r_ddst == 4'(sbce_pkg::PC_IDX)) r_res.pc <= w_quo;
                    r_st <= ST_OUT;
                end
                ST_OUT: if (i_res_pop) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT && !i_res_pop) |=> r_st == ST_OUT)
        else $error("result lost while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV) |-> !o_take) else $error("take during divide");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halt) |-> r_halt) else $error("halt cleared");
endmodule

// ===== hdl/sixteen_bit_cpu_execute_top.sv =====
// Top level of the 16-bit CPU execute block: front queue plus execute back.
// Depends on sbce_pkg, sbce_front, sbce_back.
//  channel | handshake            | payload
//  input   | i_push / full        | i_op .. i_mem_fault
//  result  | empty / pop          | o_pc .. o_instr_count
//  config  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// An item is accepted into the queue, then executed by the back; a result holds
// the back until popped. Divides also wait for the bit-serial divider.
// Synchronous active-low reset restores the register file and counters.
// The front keeps accepting up to two items while the back stalls.
`timescale 1ns / 1ps
module sixteen_bit_cpu_execute_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        full,
    input  logic        i_op,
    input  logic [15:0] i_instr,
    input  logic        i_fetch_fault,
    input  logic [15:0] i_rand_value,
    input  logic [15:0] i_seed_word,
    input  logic [15:0] i_mem_data,
    input  logic        i_mem_fault,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_pc,
    output logic [1:0]  o_mem_req,
    output logic [15:0] o_mem_addr,
    output logic [15:0] o_mem_wdata,
    output logic [1:0]  o_dma_req,
    output logic [7:0]  o_dma_device,
    output logic [15:0] o_dma_addr,
    output logic [15:0] o_dma_len,
    output logic [2:0]  o_exception,
    output logic [31:0] o_instr_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    sbce_pkg::t_item   w_in, w_q;
    sbce_pkg::t_result w_res;
    logic w_qv, w_take, w_rv;

    assign w_in = '{op: i_op, instr: i_instr, fetch_fault: i_fetch_fault,
                    rand_value: i_rand_value, seed_word: i_seed_word,
                    mem_data: i_mem_data, mem_fault: i_mem_fault};
    assign o_cfg_ready = 1'b1;
    assign empty = !w_rv;
    assign o_pc = w_res.pc;
    assign o_mem_req = w_res.mem_req;
    assign o_mem_addr = w_res.mem_addr;
    assign o_mem_wdata = w_res.mem_wdata;
    assign o_dma_req = w_res.dma_req;
    assign o_dma_device = w_res.dma_device;
    assign o_dma_addr = w_res.dma_addr;
    assign o_dma_len = w_res.dma_len;
    assign o_exception = w_res.exception;
    assign o_instr_count = w_res.instr_count;

    sbce_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(full),
        .i_item(w_in), .o_valid(w_qv), .i_take(w_take), .o_item(w_q)
    );

    sbce_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_take(w_take),
        .i_item(w_q), .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_res_valid(w_rv), .i_res_pop(pop),
        .o_res(w_res)
    );
endmodule
